### sv/register_rename_status_table_top_assert.svh
// Assertion macros for the register rename status table.
// Expects clk and rst_n in the scope of the including module.
`ifndef REGISTER_RENAME_STATUS_TABLE_TOP_ASSERT_SVH
`define REGISTER_RENAME_STATUS_TABLE_TOP_ASSERT_SVH

// Property must hold at every clock outside reset.
`define RRST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define RRST_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

### sv/rrst_pkg.sv
// Shared types and constants for the register rename status table.
// No dependencies.
package rrst_pkg;

  localparam int REG_W        = 5;
  localparam int TAG_IN_W     = 5;
  localparam int DATA_W       = 32;
  localparam int NUM_REGS_DEF = 32;
  localparam int TAG_BITS_DEF = 5;
  localparam int RET_REG      = 10;

  typedef struct packed {
    logic                flush;
    logic                commit_valid;
    logic [REG_W-1:0]    commit_reg;
    logic [TAG_IN_W-1:0] retire_tag;
    logic [DATA_W-1:0]   commit_value;
    logic                store_commit;
    logic [TAG_IN_W-1:0] issue_tag;
    logic                rename_valid;
    logic [REG_W-1:0]    rename_reg;
    logic                store_issue;
    logic [REG_W-1:0]    src_a_reg;
    logic [REG_W-1:0]    src_b_reg;
  } in_item_t;

  typedef struct packed {
    logic                src_a_ready;
    logic [DATA_W-1:0]   src_a_data;
    logic                src_b_ready;
    logic [DATA_W-1:0]   src_b_data;
    logic [TAG_IN_W-1:0] pending_store_tag;
    logic [DATA_W-1:0]   return_value_reg;
  } out_item_t;

endpackage

### sv/rrst_ram.sv
// Generic RAM: one write port and NUM_RD registered read ports.
// No dependencies; contents are undefined until written.
module rrst_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int NUM_RD = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr [NUM_RD],
  output logic [WIDTH-1:0] rdata [NUM_RD]
);

  logic [WIDTH-1:0] mem_r   [DEPTH];
  logic [WIDTH-1:0] rdata_r [NUM_RD];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      for (int i = 0; i < NUM_RD; i++) begin
        rdata_r[i] <= mem_r[raddr[i]];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/register_rename_status_table_top.sv
// Register rename status table top: value RAM, tag RAMs, pending bits, store tag.
// Depends on rrst_pkg, rrst_ram and the assertion macro header.
// Path: RAM read at accept into the stage-1 register, then the result register.
// One beat per cycle while out_ready holds; each beat's RAM write is forwarded to the next beat.
// Reset (sync, rst_n low) clears pending, written-value and store-tag state at once;
// the RAMs need no clearing pass since per-register bits mask unwritten entries.
`include "register_rename_status_table_top_assert.svh"

module register_rename_status_table_top
  import rrst_pkg::*;
#(
  parameter int NUM_REGS = NUM_REGS_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam bit RET_OK = (RET_REG < NUM_REGS);

  typedef struct packed {
    in_item_t            item;
    logic                fwd_val_a;
    logic                fwd_val_b;
    logic                fwd_tag_a;
    logic                fwd_tag_b;
    logic                fwd_tag_c;
    logic [DATA_W-1:0]   fwd_value;
    logic [TAG_BITS-1:0] fwd_tag;
  } stage_t;

  logic                s1_valid_r;
  stage_t              s1_r, s1_nxt;
  logic                out_valid_r;
  out_item_t           out_data_r, out_nxt;
  logic [NUM_REGS-1:0] pend_r, pend_nxt;
  logic [NUM_REGS-1:0] vld_r, vld_nxt;
  logic [TAG_BITS-1:0] store_tag_r, store_tag_nxt;
  logic [DATA_W-1:0]   ret_val_r, ret_val_nxt;

  logic in_acc, s1_adv;
  logic c_ok, r_ok, a_ok, b_ok, c_match;
  logic [IDX_W-1:0] c_idx, r_idx, a_idx, b_idx;
  logic [TAG_BITS-1:0] tag_a, tag_b, tag_c, eff_a, eff_b, eff_c;
  logic [DATA_W-1:0] val_a, val_b;

  logic [IDX_W-1:0]    v_raddr [2];
  logic [DATA_W-1:0]   v_rdata [2];
  logic [IDX_W-1:0]    t_raddr [2];
  logic [TAG_BITS-1:0] t_rdata [2];
  logic [IDX_W-1:0]    c_raddr [1];
  logic [TAG_BITS-1:0] c_rdata [1];

  // handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // decode of the item in flight
  always_comb begin
    c_idx = IDX_W'(s1_r.item.commit_reg);
    r_idx = IDX_W'(s1_r.item.rename_reg);
    a_idx = IDX_W'(s1_r.item.src_a_reg);
    b_idx = IDX_W'(s1_r.item.src_b_reg);
    c_ok  = s1_r.item.commit_valid && (s1_r.item.commit_reg != '0) &&
            (32'(s1_r.item.commit_reg) < 32'(NUM_REGS));
    r_ok  = s1_r.item.rename_valid && (s1_r.item.rename_reg != '0) &&
            (32'(s1_r.item.rename_reg) < 32'(NUM_REGS));
    a_ok  = (s1_r.item.src_a_reg != '0) && (32'(s1_r.item.src_a_reg) < 32'(NUM_REGS));
    b_ok  = (s1_r.item.src_b_reg != '0) && (32'(s1_r.item.src_b_reg) < 32'(NUM_REGS));
  end

  // RAM read addresses come straight from the accepted beat
  always_comb begin
    v_raddr[0] = IDX_W'(in_data.src_a_reg);
    v_raddr[1] = IDX_W'(in_data.src_b_reg);
    t_raddr[0] = IDX_W'(in_data.src_a_reg);
    t_raddr[1] = IDX_W'(in_data.src_b_reg);
    c_raddr[0] = IDX_W'(in_data.commit_reg);
  end

  rrst_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS), .NUM_RD(2)) u_val_ram (
    .clk   (clk),
    .we    (s1_adv && c_ok),
    .waddr (c_idx),
    .wdata (s1_r.item.commit_value),
    .re    (in_acc),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  rrst_ram #(.WIDTH(TAG_BITS), .DEPTH(NUM_REGS), .NUM_RD(2)) u_src_tag_ram (
    .clk   (clk),
    .we    (s1_adv && r_ok),
    .waddr (r_idx),
    .wdata (TAG_BITS'(s1_r.item.issue_tag)),
    .re    (in_acc),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // copy of the tag RAM for the commit-side tag compare
  rrst_ram #(.WIDTH(TAG_BITS), .DEPTH(NUM_REGS), .NUM_RD(1)) u_cmt_tag_ram (
    .clk   (clk),
    .we    (s1_adv && r_ok),
    .waddr (r_idx),
    .wdata (TAG_BITS'(s1_r.item.issue_tag)),
    .re    (in_acc),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // lookups: a register is pending only while its pending bit is set
  always_comb begin
    tag_a = s1_r.fwd_tag_a ? s1_r.fwd_tag : t_rdata[0];
    tag_b = s1_r.fwd_tag_b ? s1_r.fwd_tag : t_rdata[1];
    tag_c = s1_r.fwd_tag_c ? s1_r.fwd_tag : c_rdata[0];
    eff_a = (a_ok && pend_r[a_idx]) ? tag_a : '0;
    eff_b = (b_ok && pend_r[b_idx]) ? tag_b : '0;
    eff_c = (c_ok && pend_r[c_idx]) ? tag_c : '0;
    val_a = s1_r.fwd_val_a ? s1_r.fwd_value :
            ((a_ok && vld_r[a_idx]) ? v_rdata[0] : '0);
    val_b = s1_r.fwd_val_b ? s1_r.fwd_value :
            ((b_ok && vld_r[b_idx]) ? v_rdata[1] : '0);
    c_match = c_ok && (eff_c == TAG_BITS'(s1_r.item.retire_tag));

    out_nxt.src_a_ready       = !a_ok || (eff_a == '0);
    out_nxt.src_a_data        = !a_ok ? '0 : ((eff_a == '0) ? val_a : DATA_W'(eff_a));
    out_nxt.src_b_ready       = !b_ok || (eff_b == '0);
    out_nxt.src_b_data        = !b_ok ? '0 : ((eff_b == '0) ? val_b : DATA_W'(eff_b));
    out_nxt.pending_store_tag = TAG_IN_W'(store_tag_r);
    out_nxt.return_value_reg  = ret_val_r;
  end

  // state updates, applied when the beat moves to the result register
  always_comb begin
    pend_nxt      = pend_r;
    vld_nxt       = vld_r;
    ret_val_nxt   = ret_val_r;
    store_tag_nxt = store_tag_r;
    if (c_match) begin
      pend_nxt[c_idx] = 1'b0;
    end
    if (r_ok) begin
      pend_nxt[r_idx] = 1'b1;
    end
    if (c_ok) begin
      vld_nxt[c_idx] = 1'b1;
    end
    if (RET_OK && c_ok && (s1_r.item.commit_reg == REG_W'(RET_REG))) begin
      ret_val_nxt = s1_r.item.commit_value;
    end
    if (s1_r.item.store_issue) begin
      store_tag_nxt = TAG_BITS'(s1_r.item.issue_tag);
    end else if (s1_r.item.store_commit &&
                 (store_tag_r == TAG_BITS'(s1_r.item.retire_tag))) begin
      store_tag_nxt = '0;
    end
    if (s1_r.item.flush) begin
      pend_nxt      = '0;
      store_tag_nxt = '0;
    end
  end

  // forward this beat's RAM writes to the beat entering behind it
  always_comb begin
    s1_nxt.item      = in_data;
    s1_nxt.fwd_val_a = s1_adv && c_ok && (s1_r.item.commit_reg == in_data.src_a_reg);
    s1_nxt.fwd_val_b = s1_adv && c_ok && (s1_r.item.commit_reg == in_data.src_b_reg);
    s1_nxt.fwd_tag_a = s1_adv && r_ok && (s1_r.item.rename_reg == in_data.src_a_reg);
    s1_nxt.fwd_tag_b = s1_adv && r_ok && (s1_r.item.rename_reg == in_data.src_b_reg);
    s1_nxt.fwd_tag_c = s1_adv && r_ok && (s1_r.item.rename_reg == in_data.commit_reg);
    s1_nxt.fwd_value = s1_r.item.commit_value;
    s1_nxt.fwd_tag   = TAG_BITS'(s1_r.item.issue_tag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
      vld_r       <= '0;
      store_tag_r <= '0;
      ret_val_r   <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        pend_r      <= pend_nxt;
        vld_r       <= vld_nxt;
        store_tag_r <= store_tag_nxt;
        ret_val_r   <= ret_val_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_data_r <= out_nxt;
    end
  end

  `RRST_ASSERT(a_flush_clears,
    s1_adv && s1_r.item.flush |=> (pend_r == '0) && (store_tag_r == '0),
    "flush left tags pending")
  `RRST_NEVER(a_reg0_untouched, pend_r[0] || vld_r[0], "register zero state was written")
  `RRST_ASSERT(a_adv_fills_out, s1_adv |=> out_valid_r, "advanced beat missing from result register")
  `RRST_ASSERT(a_reg0_reads_zero,
    s1_valid_r && (s1_r.item.src_a_reg == '0) |->
      out_nxt.src_a_ready && (out_nxt.src_a_data == '0),
    "register zero not ready zero")

endmodule
